@@ rtl/tvrq_pkg.sv @@
// Shared types, register indexes and the class-to-category map for the track vote qualifier.
package tvrq_pkg;

    localparam int NUM_CLASSES_DEF = 6;
    localparam int VOTE_WIDTH_DEF  = 24;
    localparam int CFG_DATA_W      = 16;
    localparam int RESULT_WEIGHT_W = 24;

    localparam logic [2:0] NO_CLASS = 3'd6;

    typedef enum logic [1:0] {
        MODE_IDLE  = 2'd0,
        MODE_TRACK = 2'd1,
        MODE_LOST  = 2'd2
    } mode_t;

    typedef enum logic [2:0] {
        CFG_ROW_MIN          = 3'd0,
        CFG_ROW_MAX          = 3'd1,
        CFG_TRACK_MARGIN     = 3'd2,
        CFG_LOST_LIMIT       = 3'd3,
        CFG_MIN_TRACK_FRAMES = 3'd4,
        CFG_COOLDOWN_MS      = 3'd5
    } cfg_index_t;

    typedef enum logic [1:0] {
        CAT_SUPPLY  = 2'd0,
        CAT_VEHICLE = 2'd1,
        CAT_WEAPON  = 2'd2,
        CAT_NONE    = 2'd3
    } category_t;

    typedef struct packed {
        logic        target_found;
        logic [7:0]  target_row;
        logic [2:0]  class_index;
        logic [15:0] vote_weight;
        logic [31:0] time_ms;
    } in_item_t;

    typedef struct packed {
        logic        result_valid;
        logic [1:0]  result_category;
        logic [2:0]  result_class;
        logic [23:0] result_weight;
        logic [15:0] result_frames;
        logic [31:0] result_lost_ms;
        logic        cooldown_drop;
        logic [1:0]  track_mode;
        logic        track_confirmed;
        logic [2:0]  leading_class;
    } out_item_t;

    // Fixed map from classifier label to reported category.
    function automatic logic [1:0] class_category(input logic [2:0] cls);
        logic [1:0] cat;
        case (cls)
            3'd0:    cat = CAT_WEAPON;
            3'd1:    cat = CAT_SUPPLY;
            3'd2:    cat = CAT_VEHICLE;
            3'd3:    cat = CAT_WEAPON;
            3'd4:    cat = CAT_SUPPLY;
            3'd5:    cat = CAT_VEHICLE;
            default: cat = CAT_NONE;
        endcase
        return cat;
    endfunction

endpackage

@@ rtl/track_vote_result_qualifier_unit.sv @@
// Top level of the track vote qualifier: tracking state machine, class votes and result register.
//
// One item is taken per clock cycle while stall is low. The tracking state (mode, counters,
// per-class vote accumulators and the leading class) is updated in the same cycle the item
// is accepted, and the result item is written to the output register. A one-deep skid
// register sits behind the output register, so items keep flowing while a result waits;
// stall is raised towards the source only when both are full. The per-class vote
// accumulators are flip-flops cleared together whenever a track ends, so there is no
// clearing pass after reset. Configuration writes are always ready.
module track_vote_result_qualifier_unit #(
    parameter int NUM_CLASSES = tvrq_pkg::NUM_CLASSES_DEF,
    parameter int VOTE_WIDTH  = tvrq_pkg::VOTE_WIDTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  tvrq_pkg::in_item_t                  in_item,
    output logic                                out_valid,
    input  logic                                out_stall,
    output tvrq_pkg::out_item_t                 out_item,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [2:0]                          cfg_index,
    input  logic [tvrq_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import tvrq_pkg::*;

    localparam int CLS_W  = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
    localparam int WSAT_W = (VOTE_WIDTH > RESULT_WEIGHT_W) ? VOTE_WIDTH : RESULT_WEIGHT_W;
    localparam logic [VOTE_WIDTH-1:0] VOTE_MAX = {VOTE_WIDTH{1'b1}};

    // Configuration registers
    logic [7:0]  row_min_reg;
    logic [7:0]  row_max_reg;
    logic [3:0]  track_margin_reg;
    logic [7:0]  lost_limit_reg;
    logic [7:0]  min_frames_reg;
    logic [15:0] cooldown_reg;

    // Tracking state
    mode_t                 mode_reg,        mode_next;
    logic [15:0]           tracked_reg,     tracked_next;
    logic [7:0]            missed_reg,      missed_next;
    logic [VOTE_WIDTH-1:0] votes_reg [NUM_CLASSES];
    logic [VOTE_WIDTH-1:0] votes_next [NUM_CLASSES];
    logic [VOTE_WIDTH-1:0] best_total_reg,  best_total_next;
    logic [2:0]            best_class_reg,  best_class_next;
    logic [31:0]           miss_start_reg,  miss_start_next;
    logic [31:0]           last_emit_reg,   last_emit_next;
    logic                  have_emitted_reg, have_emitted_next;

    // Output register and skid
    logic      out_valid_reg;
    out_item_t out_reg;
    logic      skid_valid_reg;
    out_item_t skid_reg;

    logic                  in_accept;
    logic                  out_free;
    logic                  in_zone;
    logic                  cls_ok;
    logic [CLS_W-1:0]      cls_idx;
    logic [VOTE_WIDTH:0]   vote_sum;
    logic [VOTE_WIDTH-1:0] vote_sat;
    logic [7:0]            missed_inc;
    logic                  finalize;
    logic                  clear_track;
    logic                  emit;
    logic [31:0]           since_emit;
    logic [WSAT_W-1:0]     best_wide;
    out_item_t             result;

    assign cfg_ready = 1'b1;
    assign in_stall  = skid_valid_reg;
    assign in_accept = in_valid && !skid_valid_reg;
    assign out_free  = !out_valid_reg || !out_stall;
    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_min_reg      <= 8'd60;
            row_max_reg      <= 8'd200;
            track_margin_reg <= 4'd4;
            lost_limit_reg   <= 8'd5;
            min_frames_reg   <= 8'd3;
            cooldown_reg     <= 16'd1000;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_ROW_MIN:          row_min_reg      <= cfg_data[7:0];
                CFG_ROW_MAX:          row_max_reg      <= cfg_data[7:0];
                CFG_TRACK_MARGIN:     track_margin_reg <= cfg_data[3:0];
                CFG_LOST_LIMIT:       lost_limit_reg   <= cfg_data[7:0];
                CFG_MIN_TRACK_FRAMES: min_frames_reg   <= cfg_data[7:0];
                CFG_COOLDOWN_MS:      cooldown_reg     <= cfg_data;
                default:              ;
            endcase
        end
    end

    // The widened zone is tested as row + margin >= row_min and row <= row_max + margin,
    // which needs no signed arithmetic and cannot wrap.
    always_comb
    begin
        logic [8:0] margin;
        margin  = (mode_reg == MODE_TRACK) ? {5'd0, track_margin_reg} : 9'd0;
        in_zone = in_item.target_found
               && ({1'b0, in_item.target_row} + margin >= {1'b0, row_min_reg})
               && ({1'b0, in_item.target_row} <= {1'b0, row_max_reg} + margin);
    end

    assign cls_ok   = {2'b00, in_item.class_index} < 5'(NUM_CLASSES);
    assign cls_idx  = CLS_W'(in_item.class_index);
    assign vote_sum = {1'b0, votes_reg[cls_idx]} + (VOTE_WIDTH+1)'(in_item.vote_weight);
    assign vote_sat = vote_sum[VOTE_WIDTH] ? VOTE_MAX : vote_sum[VOTE_WIDTH-1:0];
    assign missed_inc = (&missed_reg) ? missed_reg : missed_reg + 8'd1;

    // Next state before any end-of-track handling.
    logic                  vote_hit;
    logic                  short_track;
    mode_t                 mode_mid;
    logic [15:0]           tracked_mid;
    logic [7:0]            missed_mid;
    logic [VOTE_WIDTH-1:0] best_total_mid;
    logic [2:0]            best_class_mid;

    always_comb
    begin
        vote_hit        = 1'b0;
        short_track     = 1'b0;
        mode_mid        = mode_reg;
        tracked_mid     = tracked_reg;
        missed_mid      = missed_reg;
        best_total_mid  = best_total_reg;
        best_class_mid  = best_class_reg;
        miss_start_next = miss_start_reg;
        if (in_zone)
        begin
            if (cls_ok)
            begin
                vote_hit = 1'b1;
                if (vote_sat > best_total_reg)
                begin
                    best_total_mid = vote_sat;
                    best_class_mid = in_item.class_index;
                end
            end
            if (mode_reg == MODE_LOST)
            begin
                missed_mid = 8'd0;
            end
            mode_mid    = MODE_TRACK;
            tracked_mid = (&tracked_reg) ? tracked_reg : tracked_reg + 16'd1;
        end
        else if (mode_reg == MODE_TRACK)
        begin
            if (missed_reg == 8'd0)
            begin
                miss_start_next = in_item.time_ms;
            end
            missed_mid = missed_inc;
            if (missed_inc >= lost_limit_reg)
            begin
                if (tracked_reg < {8'd0, min_frames_reg})
                begin
                    short_track = 1'b1;
                end
                else
                begin
                    mode_mid = MODE_LOST;
                end
            end
        end
        else if (mode_reg == MODE_LOST)
        begin
            missed_mid = missed_inc;
        end
    end

    assign finalize   = (mode_mid == MODE_LOST) && (missed_mid >= lost_limit_reg)
                     && (tracked_mid >= {8'd0, min_frames_reg});
    assign since_emit = in_item.time_ms - last_emit_reg;
    assign emit       = finalize && !(have_emitted_reg && (since_emit < {16'd0, cooldown_reg}));
    assign clear_track = short_track || finalize;
    assign best_wide  = WSAT_W'(best_total_mid);

    always_comb
    begin
        mode_next         = clear_track ? MODE_IDLE : mode_mid;
        tracked_next      = clear_track ? 16'd0 : tracked_mid;
        missed_next       = clear_track ? 8'd0 : missed_mid;
        best_total_next   = clear_track ? '0 : best_total_mid;
        best_class_next   = clear_track ? NO_CLASS : best_class_mid;
        last_emit_next    = emit ? in_item.time_ms : last_emit_reg;
        have_emitted_next = have_emitted_reg || emit;
        for (int i = 0; i < NUM_CLASSES; i++)
        begin
            if (clear_track)
            begin
                votes_next[i] = '0;
            end
            else if (vote_hit && (cls_idx == CLS_W'(i)))
            begin
                votes_next[i] = vote_sat;
            end
            else
            begin
                votes_next[i] = votes_reg[i];
            end
        end
    end

    always_comb
    begin
        result                 = '0;
        result.result_category = CAT_NONE;
        if (emit)
        begin
            result.result_valid = 1'b1;
            if (best_class_mid < NO_CLASS)
            begin
                result.result_class    = best_class_mid;
                result.result_category = class_category(best_class_mid);
            end
            result.result_weight  = (best_wide > WSAT_W'({RESULT_WEIGHT_W{1'b1}}))
                                  ? {RESULT_WEIGHT_W{1'b1}}
                                  : best_wide[RESULT_WEIGHT_W-1:0];
            result.result_frames  = tracked_mid;
            result.result_lost_ms = in_item.time_ms - miss_start_next;
        end
        result.cooldown_drop   = finalize && !emit;
        result.track_mode      = mode_next;
        result.track_confirmed = tracked_next >= {8'd0, min_frames_reg};
        result.leading_class   = best_class_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg         <= MODE_IDLE;
            tracked_reg      <= 16'd0;
            missed_reg       <= 8'd0;
            best_total_reg   <= '0;
            best_class_reg   <= NO_CLASS;
            miss_start_reg   <= 32'd0;
            last_emit_reg    <= 32'd0;
            have_emitted_reg <= 1'b0;
            for (int i = 0; i < NUM_CLASSES; i++)
            begin
                votes_reg[i] <= '0;
            end
        end
        else if (in_accept)
        begin
            mode_reg         <= mode_next;
            tracked_reg      <= tracked_next;
            missed_reg       <= missed_next;
            best_total_reg   <= best_total_next;
            best_class_reg   <= best_class_next;
            miss_start_reg   <= miss_start_next;
            last_emit_reg    <= last_emit_next;
            have_emitted_reg <= have_emitted_next;
            for (int i = 0; i < NUM_CLASSES; i++)
            begin
                votes_reg[i] <= votes_next[i];
            end
        end
    end

    // The skid only fills while the output register is held; it drains first.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg  <= skid_valid_reg || in_accept;
            skid_valid_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            out_reg <= skid_valid_reg ? skid_reg : result;
        end
        else if (in_accept)
        begin
            skid_reg <= result;
        end
    end

endmodule

@@ verif/testbench.sv @@
// Self-checking testbench for the track vote result qualifier: directed, saturation and random.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import tvrq_pkg::*;

    localparam int unsigned CYCLE_LIMIT  = 600000;
    localparam int unsigned DRAIN_CYCLES = 8;
    localparam logic [23:0] VOTE_CEILING = 24'hFF_FFFF;
    localparam category_t CLASS_CATEGORY [NUM_CLASSES_DEF] = '{
        CAT_WEAPON, CAT_SUPPLY, CAT_VEHICLE, CAT_WEAPON, CAT_SUPPLY, CAT_VEHICLE
    };

    logic                  clk;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    in_item_t              in_item = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    out_item_t             out_item;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [2:0]            cfg_index = CFG_ROW_MIN;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // Tracker state and register copies used for prediction.
    mode_t       trk_mode;
    logic [15:0] trk_frames;
    logic [7:0]  trk_misses;
    logic [23:0] trk_votes [NUM_CLASSES_DEF];
    logic [23:0] trk_best_total;
    logic [2:0]  trk_best_class;
    logic [31:0] trk_miss_start;
    logic [31:0] trk_last_emit;
    bit          trk_emitted;
    logic [7:0]  zone_lo;
    logic [7:0]  zone_hi;
    logic [3:0]  zone_margin;
    logic [7:0]  miss_limit;
    logic [7:0]  confirm_frames;
    logic [15:0] cooldown_span;

    out_item_t   pending_results [$];
    int unsigned items_sent;
    int unsigned results_seen;
    int unsigned error_count;
    int unsigned cycle_count;
    int unsigned hold_request;
    bit          tx_idle_on;
    bit          rx_idle_on;
    logic [31:0] now_ms;

    track_vote_result_qualifier_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic void drop_track();
        foreach (trk_votes[c])
            trk_votes[c] = '0;
        trk_best_total = '0;
        trk_best_class = NO_CLASS;
        trk_frames     = '0;
        trk_misses     = '0;
        trk_mode       = MODE_IDLE;
    endfunction

    function automatic void reset_tracker();
        zone_lo        = 8'd60;
        zone_hi        = 8'd200;
        zone_margin    = 4'd4;
        miss_limit     = 8'd5;
        confirm_frames = 8'd3;
        cooldown_span  = 16'd1000;
        drop_track();
        trk_miss_start = '0;
        trk_last_emit  = '0;
        trk_emitted    = 1'b0;
    endfunction

    // Advances the tracker by one frame and returns the result item it should produce.
    function automatic out_item_t qualify_frame(input in_item_t frame);
        out_item_t   res;
        int          lo;
        int          hi;
        bit          in_zone;
        logic [24:0] total;
        logic [31:0] since_emit;
        res = '0;
        res.result_category = CAT_NONE;
        lo = int'(zone_lo);
        hi = int'(zone_hi);
        if (trk_mode == MODE_TRACK)
        begin
            lo -= int'(zone_margin);
            hi += int'(zone_margin);
        end
        in_zone = frame.target_found && int'(frame.target_row) >= lo
                  && int'(frame.target_row) <= hi;
        if (in_zone)
        begin
            if (frame.class_index < NUM_CLASSES_DEF)
            begin
                total = {1'b0, trk_votes[frame.class_index]} + 25'(frame.vote_weight);
                if (total > {1'b0, VOTE_CEILING})
                    total = {1'b0, VOTE_CEILING};
                trk_votes[frame.class_index] = total[23:0];
                if (total[23:0] > trk_best_total)
                begin
                    trk_best_total = total[23:0];
                    trk_best_class = frame.class_index;
                end
            end
            if (trk_mode == MODE_LOST)
                trk_misses = '0;
            trk_mode = MODE_TRACK;
            if (trk_frames != 16'hFFFF)
                trk_frames++;
        end
        else if (trk_mode == MODE_TRACK)
        begin
            if (trk_misses == 8'd0)
                trk_miss_start = frame.time_ms;
            if (trk_misses != 8'hFF)
                trk_misses++;
            if (trk_misses >= miss_limit)
            begin
                if (trk_frames < 16'(confirm_frames))
                    drop_track();
                else
                    trk_mode = MODE_LOST;
            end
        end
        else if (trk_mode == MODE_LOST)
        begin
            if (trk_misses != 8'hFF)
                trk_misses++;
        end

        if (trk_mode == MODE_LOST && trk_misses >= miss_limit
            && trk_frames >= 16'(confirm_frames))
        begin
            since_emit = frame.time_ms - trk_last_emit;
            if (trk_emitted && since_emit < 32'(cooldown_span))
                res.cooldown_drop = 1'b1;
            else
            begin
                res.result_valid = 1'b1;
                if (trk_best_class < NUM_CLASSES_DEF)
                begin
                    res.result_class    = trk_best_class;
                    res.result_category = CLASS_CATEGORY[trk_best_class];
                end
                res.result_weight  = trk_best_total;
                res.result_frames  = trk_frames;
                res.result_lost_ms = frame.time_ms - trk_miss_start;
                trk_last_emit      = frame.time_ms;
                trk_emitted        = 1'b1;
            end
            drop_track();
        end
        res.track_mode      = trk_mode;
        res.track_confirmed = trk_frames >= 16'(confirm_frames);
        res.leading_class   = trk_best_class;
        return res;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            error_count++;
            if (error_count <= 10)
                $display("Mismatch in %s of result %0d: expected %0h, got %0h",
                         name, results_seen, want, got);
        end
    endtask

    // Register writes, accepted frames and delivered results are all observed here at the edge.
    always @(posedge clk)
    begin : frame_monitor
        out_item_t want;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_ROW_MIN:          zone_lo        = cfg_data[7:0];
                    CFG_ROW_MAX:          zone_hi        = cfg_data[7:0];
                    CFG_TRACK_MARGIN:     zone_margin    = cfg_data[3:0];
                    CFG_LOST_LIMIT:       miss_limit     = cfg_data[7:0];
                    CFG_MIN_TRACK_FRAMES: confirm_frames = cfg_data[7:0];
                    CFG_COOLDOWN_MS:      cooldown_span  = cfg_data[15:0];
                    default: ;
                endcase
            end
            if (in_valid && !in_stall)
                pending_results.push_back(qualify_frame(in_item));
            if (out_valid && !out_stall)
            begin
                results_seen++;
                if (pending_results.size() == 0)
                begin
                    error_count++;
                    if (error_count <= 10)
                        $display("Result %0d arrived with nothing expected", results_seen);
                end
                else
                begin
                    want = pending_results.pop_front();
                    check_field("result_valid", 32'(want.result_valid),
                                32'(out_item.result_valid));
                    check_field("result_category", 32'(want.result_category),
                                32'(out_item.result_category));
                    check_field("result_class", 32'(want.result_class),
                                32'(out_item.result_class));
                    check_field("result_weight", 32'(want.result_weight),
                                32'(out_item.result_weight));
                    check_field("result_frames", 32'(want.result_frames),
                                32'(out_item.result_frames));
                    check_field("result_lost_ms", want.result_lost_ms, out_item.result_lost_ms);
                    check_field("cooldown_drop", 32'(want.cooldown_drop),
                                32'(out_item.cooldown_drop));
                    check_field("track_mode", 32'(want.track_mode), 32'(out_item.track_mode));
                    check_field("track_confirmed", 32'(want.track_confirmed),
                                32'(out_item.track_confirmed));
                    check_field("leading_class", 32'(want.leading_class),
                                32'(out_item.leading_class));
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Result side: random stall bursts, or one long hold-off when asked for.
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_request != 0)
            begin
                out_stall <= 1'b1;
                repeat (hold_request) @(posedge clk);
                hold_request = 0;
                out_stall <= 1'b0;
            end
            else if (rx_idle_on && $urandom_range(0, 5) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 15)) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    task automatic send_frame(input bit found, input logic [7:0] row, input logic [2:0] cls,
                              input logic [15:0] weight, input int unsigned step_ms);
        in_item_t frame;
        if (tx_idle_on && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
        now_ms = now_ms + step_ms;
        frame.target_found = found;
        frame.target_row   = row;
        frame.class_index  = cls;
        frame.vote_weight  = weight;
        frame.time_ms      = now_ms;
        in_item  <= frame;
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        items_sent++;
    endtask

    task automatic settle_block();
        in_valid <= 1'b0;
        while (results_seen < items_sent)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic put_register(input cfg_index_t idx, input logic [15:0] value);
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
    endtask

    task automatic apply_config(input logic [7:0] lo, input logic [7:0] hi,
                                input logic [3:0] margin, input logic [7:0] limit,
                                input logic [7:0] frames, input logic [15:0] cooldown);
        cfg_valid <= 1'b1;
        put_register(CFG_ROW_MIN, 16'(lo));
        put_register(CFG_ROW_MAX, 16'(hi));
        put_register(CFG_TRACK_MARGIN, 16'(margin));
        put_register(CFG_LOST_LIMIT, 16'(limit));
        put_register(CFG_MIN_TRACK_FRAMES, 16'(frames));
        put_register(CFG_COOLDOWN_MS, cooldown);
        cfg_valid <= 1'b0;
    endtask

    task automatic random_settings();
        logic [7:0]  lo;
        logic [15:0] cooldown;
        lo = 8'($urandom_range(0, 120));
        case ($urandom_range(0, 2))
            0:       cooldown = 16'd0;
            1:       cooldown = 16'($urandom_range(0, 600));
            default: cooldown = 16'($urandom);
        endcase
        apply_config(lo, 8'($urandom_range(lo, 255)), 4'($urandom), 8'($urandom_range(0, 6)),
                     8'($urandom_range(0, 5)), cooldown);
    endtask

    function automatic int unsigned frame_gap();
        if ($urandom_range(0, 19) == 0)
            return $urandom_range(0, 5000);
        return $urandom_range(1, 80);
    endfunction

    function automatic logic [15:0] pick_weight();
        case ($urandom_range(0, 7))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_hit(input logic [2:0] cls);
        int lo;
        int hi;
        lo = int'(zone_lo);
        hi = int'(zone_hi);
        // Now and then aim into the widened band that only counts while tracking.
        if ($urandom_range(0, 5) == 0)
        begin
            lo = (lo > int'(zone_margin)) ? lo - int'(zone_margin) : 0;
            hi = (hi + int'(zone_margin) < 255) ? hi + int'(zone_margin) : 255;
        end
        send_frame(1'b1, 8'($urandom_range(lo, hi)), cls, pick_weight(), frame_gap());
    endtask

    task automatic send_miss();
        int below;
        int above;
        below = int'(zone_lo) - int'(zone_margin) - 1;
        above = int'(zone_hi) + int'(zone_margin) + 1;
        if ($urandom_range(0, 1) == 0 && below >= 0)
            send_frame(1'b1, 8'($urandom_range(0, below)), 3'($urandom), pick_weight(),
                       frame_gap());
        else if ($urandom_range(0, 1) == 0 && above <= 255)
            send_frame(1'b1, 8'($urandom_range(above, 255)), 3'($urandom), pick_weight(),
                       frame_gap());
        else
            send_frame(1'b0, 8'($urandom), 3'($urandom), pick_weight(), frame_gap());
    endtask

    // One well-formed track with random content, or now and then a single noise frame.
    task automatic run_random_track(inout int unsigned count);
        int unsigned len;
        int unsigned misses;
        logic [2:0]  fav;
        if ($urandom_range(0, 9) == 0)
        begin
            send_frame(1'($urandom), 8'($urandom), 3'($urandom), 16'($urandom), frame_gap());
            count++;
        end
        else
        begin
            len = $urandom_range(0, 8);
            fav = 3'($urandom);
            repeat (len)
            begin
                if ($urandom_range(0, 7) == 0)
                    send_miss();
                else
                    send_hit(($urandom_range(0, 3) != 0) ? fav : 3'($urandom));
                count++;
            end
            misses = ($urandom_range(0, 4) == 0) ? $urandom_range(0, miss_limit)
                                                 : miss_limit + 1;
            repeat (misses)
            begin
                send_miss();
                count++;
            end
        end
    endtask

    task automatic test_reset_defaults();
        // Zone 60..200, margin 4, five misses, three frames, one second cooldown.
        send_frame(1'b0, 8'd100, 3'd0, 16'h0000, 33);
        send_frame(1'b1, 8'd59, 3'd1, 16'hFFFF, 33);
        send_frame(1'b1, 8'd60, 3'd0, 16'hFFFF, 33);
        send_frame(1'b1, 8'd204, 3'd7, 16'h1234, 33);
        send_frame(1'b1, 8'd205, 3'd2, 16'h0010, 33);
        // A tie does not take the lead; one more unit does.
        send_frame(1'b1, 8'd200, 3'd3, 16'hFFFF, 33);
        send_frame(1'b1, 8'd150, 3'd3, 16'h0001, 33);
        // The earlier miss still counts, so four more end the track.
        repeat (4) send_frame(1'b0, 8'd255, 3'd5, 16'hFFFF, 33);
    endtask

    task automatic test_special_settings();
        settle_block();
        apply_config(8'd0, 8'd255, 4'd15, 8'd0, 8'd0, 16'd0);
        // No vote at all, then the first miss ends the track at once.
        send_frame(1'b1, 8'd0, 3'd7, 16'h0000, 10);
        send_frame(1'b0, 8'd0, 3'd0, 16'h0000, 10);
        send_frame(1'b1, 8'd255, 3'd5, 16'h8000, 10);
        send_frame(1'b0, 8'd0, 3'd0, 16'h0000, 10);

        settle_block();
        apply_config(8'd255, 8'd0, 4'd0, 8'd1, 8'd2, 16'hFFFF);
        send_frame(1'b1, 8'd128, 3'd2, 16'h00FF, 10);

        settle_block();
        apply_config(8'd100, 8'd100, 4'd15, 8'd2, 8'd2, 16'd0);
        // Finalise across the timestamp wrap, then discard a one-frame track.
        now_ms = 32'hFFFF_FFF0;
        send_frame(1'b1, 8'd100, 3'd4, 16'hFFFF, 0);
        send_frame(1'b1, 8'd85, 3'd6, 16'h0007, 5);
        send_frame(1'b1, 8'd84, 3'd1, 16'h0007, 5);
        send_frame(1'b0, 8'd100, 3'd1, 16'h0007, 20);
        send_frame(1'b1, 8'd100, 3'd1, 16'h0100, 5);
        repeat (2) send_frame(1'b0, 8'd100, 3'd1, 16'h0000, 5);

        settle_block();
        apply_config(8'd100, 8'd100, 4'd15, 8'd2, 8'd2, 16'hFFFF);
        repeat (2) send_frame(1'b1, 8'd100, 3'd5, 16'h0200, 5);
        repeat (2) send_frame(1'b0, 8'd100, 3'd5, 16'h0000, 5);
    endtask

    task automatic test_vote_saturation();
        settle_block();
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        apply_config(8'd60, 8'd200, 4'd4, 8'd2, 8'd255, 16'd0);
        // Long enough for the vote total to saturate and the track to be confirmed.
        repeat (260) send_frame(1'b1, 8'd100, 3'd2, 16'hFFFF, 1);
        repeat (2) send_frame(1'b0, 8'd100, 3'd2, 16'h0000, 1);
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
    endtask

    task automatic test_output_backpressure();
        int unsigned count;
        settle_block();
        random_settings();
        tx_idle_on   = 1'b0;
        hold_request = 300;
        count = 0;
        while (count < 40)
            run_random_track(count);
        tx_idle_on = 1'b1;
    endtask

    task automatic test_random_tracks(input int unsigned phases, input int unsigned per_phase);
        int unsigned count;
        for (int p = 0; p < int'(phases); p++)
        begin
            settle_block();
            random_settings();
            count = 0;
            while (count < per_phase)
                run_random_track(count);
        end
    endtask

    task automatic test_steady_tail();
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        test_random_tracks(1, 40);
    endtask

    initial
    begin
        reset_tracker();
        now_ms     = $urandom;
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        test_reset_defaults();
        test_special_settings();
        test_vote_saturation();
        test_output_backpressure();
        test_random_tracks(4, 40);
        test_steady_tail();

        settle_block();
        if (pending_results.size() != 0)
            error_count++;
        if (error_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
